// ===== sv/fsmc_pkg.sv =====
// Shared types and constants for the flash sector map chunker.
package fsmc_pkg;

  // Register file layout
  localparam int REG_SLOTS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register index of the page size exponent
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_EXP = 3'd4;

  // Region descriptor packing
  localparam int CNT_W   = 16;
  localparam int EXP_W   = 5;
  localparam int OP_W    = 8;
  localparam int CNT_LSB = 0;
  localparam int EXP_LSB = 16;
  localparam int OP_LSB  = 24;

  // Data widths
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 32;
  localparam int RIDX_W    = 2;
  localparam int CHUNK_W   = 17;
  localparam int SEC_REM_W = 32;
  localparam int SPAN_W    = CNT_W + (1 << EXP_W) - 1;
  localparam int SUM_W     = SPAN_W + $clog2(REG_SLOTS);

  // Page exponent limits
  localparam int                PAGE_EXP_MAX = 16;
  localparam logic [EXP_W-1:0]  PAGE_EXP_RST = 5'd8;

  // Defaults for top-level parameters
  localparam int DEF_NUM_REGIONS = 4;
  localparam int DEF_ADDR_BITS   = 32;

  // Per-region values derived from the descriptors
  typedef struct packed {
    logic             active;   // this and all earlier regions have a nonzero count
    logic             next_nz;  // the following region has a nonzero count
    logic [CNT_W-1:0] cnt;
    logic [EXP_W-1:0] ex;
    logic [OP_W-1:0]  op;
    logic [SUM_W-1:0] start;
    logic [SUM_W-1:0] stop;
  } region_info_t;

  // Lookup result handed from the region locator to the chunk sizer
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [RIDX_W-1:0] ridx;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [EXP_W-1:0]  ex;
    logic [OP_W-1:0]   op;
    logic [CNT_W-1:0]  cnt;
    logic              next_nz;
  } loc_t;

endpackage

// ===== sv/fsmc_regs.sv =====
// Configuration registers and the derived region start/end table.
module fsmc_regs #(
  parameter int NUM_REGIONS = fsmc_pkg::DEF_NUM_REGIONS,
  localparam int SCAN_N = (NUM_REGIONS < fsmc_pkg::REG_SLOTS) ?
                          NUM_REGIONS : fsmc_pkg::REG_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fsmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsmc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output fsmc_pkg::region_info_t            info_o [SCAN_N],
  output logic [fsmc_pkg::EXP_W-1:0]        page_exp_o
);
  import fsmc_pkg::*;

  logic [CFG_DATA_W-1:0] region_r [SCAN_N];
  logic [EXP_W-1:0]      page_exp_r;
  region_info_t          info_r   [SCAN_N];
  region_info_t          info_nxt [SCAN_N];

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < SCAN_N; r++) region_r[r] <= '0;
      page_exp_r <= PAGE_EXP_RST;
    end else if (cfg_we) begin
      for (int r = 0; r < SCAN_N; r++) begin
        if (cfg_index == CFG_IDX_W'(r)) region_r[r] <= cfg_data;
      end
      if (cfg_index == REG_PAGE_EXP) page_exp_r <= cfg_data[EXP_W-1:0];
    end
  end

  // Region spans, running start/end and table-end tracking
  always_comb begin
    logic [SUM_W-1:0] acc;
    logic             alive;
    logic             carry;
    logic [CNT_W-1:0] cnt;
    logic [EXP_W-1:0] ex;
    acc   = '0;
    alive = 1'b1;
    for (int r = 0; r < SCAN_N; r++) begin
      cnt   = region_r[r][CNT_LSB +: CNT_W];
      ex    = region_r[r][EXP_LSB +: EXP_W];
      alive = alive & (cnt != '0);
      info_nxt[r].active  = alive;
      info_nxt[r].next_nz = 1'b0;
      info_nxt[r].cnt     = cnt;
      info_nxt[r].ex      = ex;
      info_nxt[r].op      = region_r[r][OP_LSB +: OP_W];
      info_nxt[r].start   = acc;
      info_nxt[r].stop    = acc + (SUM_W'(cnt) << ex);
      acc                 = info_nxt[r].stop;
    end
    // walk backwards so each region sees the count of its successor
    carry = 1'b0;
    for (int r = SCAN_N - 1; r >= 0; r--) begin
      info_nxt[r].next_nz = carry;
      carry = (region_r[r][CNT_LSB +: CNT_W] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < SCAN_N; r++) info_r[r] <= '0;
    end else begin
      for (int r = 0; r < SCAN_N; r++) info_r[r] <= info_nxt[r];
    end
  end

  assign info_o     = info_r;
  assign page_exp_o = (page_exp_r > EXP_W'(PAGE_EXP_MAX)) ? EXP_W'(PAGE_EXP_MAX) : page_exp_r;

endmodule

// ===== sv/fsmc_locate.sv =====
// Input capture and parallel region compare: finds the region holding the address.
module fsmc_locate #(
  parameter int NUM_REGIONS = fsmc_pkg::DEF_NUM_REGIONS,
  parameter int ADDR_BITS   = fsmc_pkg::DEF_ADDR_BITS,
  localparam int SCAN_N = (NUM_REGIONS < fsmc_pkg::REG_SLOTS) ?
                          NUM_REGIONS : fsmc_pkg::REG_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic [fsmc_pkg::ADDR_W-1:0]    address,
  input  logic [fsmc_pkg::LEN_W-1:0]     length,
  input  fsmc_pkg::region_info_t         info_i [SCAN_N],
  output fsmc_pkg::loc_t                 loc_o
);
  import fsmc_pkg::*;

  logic                 s1_valid_r;
  logic [ADDR_BITS-1:0] s1_addr_r;
  logic [LEN_W-1:0]     s1_len_r;
  logic                 hit   [SCAN_N];
  logic [ADDR_BITS-1:0] off_w [SCAN_N];
  loc_t                 loc_r;
  loc_t                 loc_nxt;

  // Stage 1: capture the accepted transfer, upper address bits dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr_r <= address[ADDR_BITS-1:0];
      s1_len_r  <= length;
    end
  end

  // Stage 2: compare against every region end and form offsets in parallel
  always_comb begin
    for (int r = 0; r < SCAN_N; r++) begin
      hit[r]   = info_i[r].active && (SUM_W'(s1_addr_r) < info_i[r].stop);
      off_w[r] = s1_addr_r - info_i[r].start[ADDR_BITS-1:0];
    end
  end

  // Lowest matching region wins
  always_comb begin
    loc_nxt       = '0;
    loc_nxt.valid = s1_valid_r;
    loc_nxt.addr  = ADDR_W'(s1_addr_r);
    loc_nxt.len   = s1_len_r;
    for (int r = SCAN_N - 1; r >= 0; r--) begin
      if (hit[r]) begin
        loc_nxt.found   = 1'b1;
        loc_nxt.ridx    = RIDX_W'(r);
        loc_nxt.off     = ADDR_W'(off_w[r]);
        loc_nxt.start   = ADDR_W'(info_i[r].start[ADDR_BITS-1:0]);
        loc_nxt.ex      = info_i[r].ex;
        loc_nxt.op      = info_i[r].op;
        loc_nxt.cnt     = info_i[r].cnt;
        loc_nxt.next_nz = info_i[r].next_nz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r <= '0;
    end else begin
      loc_r <= loc_nxt;
    end
  end

  assign loc_o = loc_r;

endmodule

// ===== sv/fsmc_sizer.sv =====
// Sector index, base and program chunk sizing, with the output register.
module fsmc_sizer #(
  parameter int ADDR_BITS = fsmc_pkg::DEF_ADDR_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fsmc_pkg::loc_t                  loc_i,
  input  logic [fsmc_pkg::EXP_W-1:0]      page_exp_i,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [fsmc_pkg::RIDX_W-1:0]     out_region_index,
  output logic [fsmc_pkg::CNT_W-1:0]      out_sector_index,
  output logic [fsmc_pkg::ADDR_W-1:0]     out_sector_base,
  output logic [fsmc_pkg::EXP_W-1:0]      out_sector_size_exp,
  output logic [fsmc_pkg::OP_W-1:0]       out_erase_opcode,
  output logic [fsmc_pkg::CHUNK_W-1:0]    out_chunk_length,
  output logic                            out_more_sectors
);
  import fsmc_pkg::*;

  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [RIDX_W-1:0]    ridx;
    logic [CNT_W-1:0]     idx;
    logic [ADDR_BITS-1:0] base_off;
    logic [ADDR_BITS-1:0] start;
    logic [EXP_W-1:0]     ex;
    logic [OP_W-1:0]      op;
    logic [CNT_W-1:0]     cnt;
    logic                 next_nz;
    logic [LEN_W-1:0]     len;
    logic [SEC_REM_W-1:0] sec_rem;
    logic [CHUNK_W-1:0]   page_rem;
  } s3_t;

  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [RIDX_W-1:0]    ridx;
    logic [CNT_W-1:0]     idx;
    logic [ADDR_BITS-1:0] base;
    logic [EXP_W-1:0]     ex;
    logic [OP_W-1:0]      op;
    logic                 more;
    logic [LEN_W-1:0]     len;
    logic [CHUNK_W-1:0]   lim;
  } s4_t;

  s3_t                  s3_r, s3_nxt;
  s4_t                  s4_r, s4_nxt;
  logic [ADDR_W:0]      sec_pow;
  logic [ADDR_W-1:0]    sec_mask;
  logic [ADDR_W-1:0]    off_ext;
  logic [CHUNK_W:0]     page_pow;
  logic [CHUNK_W-1:0]   page_mask;
  logic [CHUNK_W-1:0]   chunk_w;

  // Stage 3: split the offset into sector index and in-sector offset; form bytes left to sector end and page end
  always_comb begin
    off_ext   = ADDR_W'(loc_i.off[ADDR_BITS-1:0]);
    sec_pow   = (ADDR_W+1)'(1) << loc_i.ex;
    sec_mask  = ADDR_W'(sec_pow - (ADDR_W+1)'(1));
    page_pow  = (CHUNK_W+1)'(1) << page_exp_i;
    page_mask = CHUNK_W'(page_pow - (CHUNK_W+1)'(1));

    s3_nxt.valid    = loc_i.valid;
    s3_nxt.found    = loc_i.found;
    s3_nxt.ridx     = loc_i.ridx;
    s3_nxt.idx      = CNT_W'(off_ext >> loc_i.ex);
    s3_nxt.base_off = ADDR_BITS'(off_ext & ~sec_mask);
    s3_nxt.start    = loc_i.start[ADDR_BITS-1:0];
    s3_nxt.ex       = loc_i.ex;
    s3_nxt.op       = loc_i.op;
    s3_nxt.cnt      = loc_i.cnt;
    s3_nxt.next_nz  = loc_i.next_nz;
    s3_nxt.len      = loc_i.len;
    s3_nxt.sec_rem  = SEC_REM_W'(sec_pow - (ADDR_W+1)'(off_ext & sec_mask));
    s3_nxt.page_rem = CHUNK_W'(page_pow -
                      (CHUNK_W+1)'(CHUNK_W'(loc_i.addr[CHUNK_W-2:0]) & page_mask));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= '0;
    end else begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 4: sector base, nearer of sector end and page end, more flag
  always_comb begin
    s4_nxt.valid = s3_r.valid;
    s4_nxt.found = s3_r.found;
    s4_nxt.ridx  = s3_r.ridx;
    s4_nxt.idx   = s3_r.idx;
    s4_nxt.base  = s3_r.start + s3_r.base_off;
    s4_nxt.ex    = s3_r.ex;
    s4_nxt.op    = s3_r.op;
    s4_nxt.more  = ((CNT_W+1)'(s3_r.idx) + (CNT_W+1)'(1) < (CNT_W+1)'(s3_r.cnt)) ||
                   s3_r.next_nz;
    s4_nxt.len   = s3_r.len;
    s4_nxt.lim   = (s3_r.sec_rem < SEC_REM_W'(s3_r.page_rem)) ?
                   CHUNK_W'(s3_r.sec_rem) : s3_r.page_rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r <= '0;
    end else begin
      s4_r <= s4_nxt;
    end
  end

  // Output register: cut to the remaining length, zeros when not found
  assign chunk_w = (s4_r.len < LEN_W'(s4_r.lim)) ? CHUNK_W'(s4_r.len) : s4_r.lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s4_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_r.found) begin
      out_found           <= 1'b1;
      out_region_index    <= s4_r.ridx;
      out_sector_index    <= s4_r.idx;
      out_sector_base     <= ADDR_W'(s4_r.base);
      out_sector_size_exp <= s4_r.ex;
      out_erase_opcode    <= s4_r.op;
      out_chunk_length    <= chunk_w;
      out_more_sectors    <= s4_r.more;
    end else begin
      out_found           <= 1'b0;
      out_region_index    <= '0;
      out_sector_index    <= '0;
      out_sector_base     <= '0;
      out_sector_size_exp <= '0;
      out_erase_opcode    <= '0;
      out_chunk_length    <= '0;
      out_more_sectors    <= 1'b0;
    end
  end

endmodule

// ===== sv/flash_sector_map_chunker.sv =====
// Top level of the flash sector map chunker.
//
// Usage: write the erase region descriptors (indexes 0..3) and the page size
// exponent (index 4) through the cfg_ port while no transfer is in flight; a
// new value is in effect for a transfer started in the following cycle.
// A transfer is started by raising start with in_address and in_length; busy
// is always low, so one transfer can be started in every clock cycle.
// Each result shows on the out_ ports, marked by out_valid, for one cycle.
// Throughput: one result per cycle, since busy never holds off a start.
// The work runs through an input capture stage, a parallel region compare,
// a sector split stage, a chunk limit stage and the output register.
// Results leave in start order; the receiver must take each one when shown.
// Reset (synchronous, rst_n low) clears all region descriptors, which empties
// the table, sets the page exponent to 8 and drops every transfer in flight.
module flash_sector_map_chunker #(
  parameter int NUM_REGIONS = fsmc_pkg::DEF_NUM_REGIONS,
  parameter int ADDR_BITS   = fsmc_pkg::DEF_ADDR_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [fsmc_pkg::ADDR_W-1:0]     in_address,
  input  logic [fsmc_pkg::LEN_W-1:0]      in_length,
  input  logic                            cfg_we,
  input  logic [fsmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [fsmc_pkg::RIDX_W-1:0]     out_region_index,
  output logic [fsmc_pkg::CNT_W-1:0]      out_sector_index,
  output logic [fsmc_pkg::ADDR_W-1:0]     out_sector_base,
  output logic [fsmc_pkg::EXP_W-1:0]      out_sector_size_exp,
  output logic [fsmc_pkg::OP_W-1:0]       out_erase_opcode,
  output logic [fsmc_pkg::CHUNK_W-1:0]    out_chunk_length,
  output logic                            out_more_sectors
);
  import fsmc_pkg::*;

  localparam int SCAN_N = (NUM_REGIONS < REG_SLOTS) ? NUM_REGIONS : REG_SLOTS;

  region_info_t     info [SCAN_N];
  logic [EXP_W-1:0] page_exp;
  loc_t             loc;

  // Fully pipelined, never holds off a transfer
  assign busy = 1'b0;

  fsmc_regs #(
    .NUM_REGIONS (NUM_REGIONS)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .info_o     (info),
    .page_exp_o (page_exp)
  );

  fsmc_locate #(
    .NUM_REGIONS (NUM_REGIONS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_locate (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (start && !busy),
    .address (in_address),
    .length  (in_length),
    .info_i  (info),
    .loc_o   (loc)
  );

  fsmc_sizer #(
    .ADDR_BITS (ADDR_BITS)
  ) u_sizer (
    .clk                 (clk),
    .rst_n               (rst_n),
    .loc_i               (loc),
    .page_exp_i          (page_exp),
    .out_valid           (out_valid),
    .out_found           (out_found),
    .out_region_index    (out_region_index),
    .out_sector_index    (out_sector_index),
    .out_sector_base     (out_sector_base),
    .out_sector_size_exp (out_sector_size_exp),
    .out_erase_opcode    (out_erase_opcode),
    .out_chunk_length    (out_chunk_length),
    .out_more_sectors    (out_more_sectors)
  );

endmodule
